// File: hdl/dpll_pkg.sv
package dpll_pkg;

  localparam int unsigned DataW = 16;
  localparam int unsigned AccW  = 32;
  localparam int unsigned MulW  = 17;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CENTER_STEP = 3'd0,
    REG_GAIN        = 3'd1,
    REG_ALPHA       = 3'd2,
    REG_ERR_SCALE   = 3'd3,
    REG_DECIMATION  = 3'd4,
    REG_BP_GAIN     = 3'd5,
    REG_BP_POLE     = 3'd6,
    REG_UNUSED      = 3'd7
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GAIN,
    ST_INTERP,
    ST_PD,
    ST_LA,
    ST_LB,
    ST_ES,
    ST_KF,
    ST_A1,
    ST_BP0,
    ST_BP1,
    ST_BP2,
    ST_BP3,
    ST_OUT
  } seq_state_e;

  localparam logic [15:0] RstCenterStep = 16'sd16384;
  localparam logic [15:0] RstGain       = 16'sd24381;
  localparam logic [14:0] RstAlpha      = 15'd31530;
  localparam logic [15:0] RstErrScale   = 16'sd23570;
  localparam logic [7:0]  RstDecimation = 8'd32;
  localparam logic [15:0] RstBpGain     = 16'sd2391;
  localparam logic [15:0] RstBpPole     = -16'sd27987;
  localparam logic [15:0] QOne          = 16'h7FFF;

  // half-sine table, 33 points over half a period
  function automatic logic [15:0] half_sine(input logic [5:0] idx);
    logic [15:0] v;
    case (idx)
      6'd0:  v = 16'd0;
      6'd1:  v = 16'd3212;
      6'd2:  v = 16'd6393;
      6'd3:  v = 16'd9512;
      6'd4:  v = 16'd12539;
      6'd5:  v = 16'd15446;
      6'd6:  v = 16'd18204;
      6'd7:  v = 16'd20787;
      6'd8:  v = 16'd23170;
      6'd9:  v = 16'd25329;
      6'd10: v = 16'd27245;
      6'd11: v = 16'd28898;
      6'd12: v = 16'd30273;
      6'd13: v = 16'd31356;
      6'd14: v = 16'd32137;
      6'd15: v = 16'd32609;
      6'd16: v = 16'd32767;
      6'd17: v = 16'd32609;
      6'd18: v = 16'd32137;
      6'd19: v = 16'd31356;
      6'd20: v = 16'd30273;
      6'd21: v = 16'd28898;
      6'd22: v = 16'd27245;
      6'd23: v = 16'd25329;
      6'd24: v = 16'd23170;
      6'd25: v = 16'd20787;
      6'd26: v = 16'd18204;
      6'd27: v = 16'd15446;
      6'd28: v = 16'd12539;
      6'd29: v = 16'd9512;
      6'd30: v = 16'd6393;
      6'd31: v = 16'd3212;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

// File: hdl/dpll_fm_demod_tracking_filter_core.sv
// Channel  | Handshake                  | Payload
// ---------+----------------------------+---------------------------------------------
// input    | in_valid_i / in_stall_o    | sample_in_i
// output   | out_valid_o / out_stall_i  | loop_error_out_o, control_word_o, filtered_out_o
// config   | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// Each word makes 12 passes through the single 17x17 multiplier,
// plus accept and result load. The input stalls from accept until the result
// is loaded into the output register; a stalled output holds the sequencer in
// its final step. Reset clears all loop state and loads default coefficients.
module dpll_fm_demod_tracking_filter_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] sample_in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] loop_error_out_o,
  output logic signed [15:0] control_word_o,
  output logic signed [15:0] filtered_out_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  localparam logic [14:0] QOneLow = dpll_pkg::QOne[14:0];

  dpll_pkg::seq_state_e state_q, state_d;

  logic [15:0] center_q, gain_q, escale_q, bpgain_q, bppole_q;
  logic [14:0] alpha_q;
  logic [7:0]  decim_q;

  logic [15:0] phase_q, err_q, held_q, bpo1_q, bpo2_q, bpi1_q, bpi2_q;
  logic [31:0] integ_q, comb_q, acc_q;
  logic [7:0]  dcnt_q;
  logic [15:0] x_q, y_q, xd_q, enew_q, a1_q, yn_q;
  logic [16:0] kf_q;

  logic               out_valid_q;
  logic [15:0]        out_err_q, out_cw_q, out_yn_q;

  logic signed [16:0] mul_a, mul_b;
  logic signed [33:0] prod;
  logic [31:0]        p32, acc_sum;

  logic [4:0]  ph_idx, cw_idx;
  logic [16:0] ph_diff, cw_diff;
  logic [15:0] ex, b2;
  logic [31:0] integ_new;
  logic        out_free;

  assign cfg_ready_o = (state_q == dpll_pkg::ST_IDLE);
  assign in_stall_o  = (state_q != dpll_pkg::ST_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;

  assign ph_idx  = phase_q[14:10];
  assign cw_idx  = held_q[15:11];
  assign ph_diff = 17'(dpll_pkg::half_sine({1'b0, ph_idx} + 6'd1))
                 - 17'(dpll_pkg::half_sine({1'b0, ph_idx}));
  assign cw_diff = 17'(dpll_pkg::half_sine({1'b0, cw_idx} + 6'd1))
                 - 17'(dpll_pkg::half_sine({1'b0, cw_idx}));
  assign b2 = 16'(-bpgain_q);

  assign prod    = mul_a * mul_b;
  assign p32     = prod[31:0];
  assign acc_sum = acc_q + p32;
  assign ex      = p32[29:14];
  assign integ_new = integ_q + {{16{ex[15]}}, ex};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      dpll_pkg::ST_IDLE:   if (in_valid_i) state_d = dpll_pkg::ST_GAIN;
      dpll_pkg::ST_GAIN:   state_d = dpll_pkg::ST_INTERP;
      dpll_pkg::ST_INTERP: state_d = dpll_pkg::ST_PD;
      dpll_pkg::ST_PD:     state_d = dpll_pkg::ST_LA;
      dpll_pkg::ST_LA:     state_d = dpll_pkg::ST_LB;
      dpll_pkg::ST_LB:     state_d = dpll_pkg::ST_ES;
      dpll_pkg::ST_ES:     state_d = dpll_pkg::ST_KF;
      dpll_pkg::ST_KF:     state_d = dpll_pkg::ST_A1;
      dpll_pkg::ST_A1:     state_d = dpll_pkg::ST_BP0;
      dpll_pkg::ST_BP0:    state_d = dpll_pkg::ST_BP1;
      dpll_pkg::ST_BP1:    state_d = dpll_pkg::ST_BP2;
      dpll_pkg::ST_BP2:    state_d = dpll_pkg::ST_BP3;
      dpll_pkg::ST_BP3:    state_d = dpll_pkg::ST_OUT;
      dpll_pkg::ST_OUT:    if (out_free) state_d = dpll_pkg::ST_IDLE;
      default:             state_d = dpll_pkg::ST_IDLE;
    endcase
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      dpll_pkg::ST_GAIN: begin
        mul_a = 17'($signed(err_q));   mul_b = 17'($signed(gain_q));
      end
      dpll_pkg::ST_INTERP: begin
        mul_a = $signed(ph_diff);      mul_b = $signed({2'b00, phase_q[9:0], 5'b0});
      end
      dpll_pkg::ST_PD: begin
        mul_a = 17'($signed(x_q));     mul_b = 17'($signed(y_q));
      end
      dpll_pkg::ST_LA: begin
        mul_a = $signed({2'b00, alpha_q}); mul_b = 17'($signed(err_q));
      end
      dpll_pkg::ST_LB: begin
        mul_a = 17'($signed(xd_q));
        mul_b = $signed({2'b00, QOneLow - alpha_q});
      end
      dpll_pkg::ST_ES: begin
        mul_a = 17'($signed(enew_q));  mul_b = 17'($signed(escale_q));
      end
      dpll_pkg::ST_KF: begin
        mul_a = $signed(cw_diff);      mul_b = $signed({2'b00, held_q[10:1], 5'b0});
      end
      dpll_pkg::ST_A1: begin
        mul_a = $signed(kf_q);
        mul_b = $signed({1'b0, dpll_pkg::QOne} - 17'($signed(bpgain_q)));
      end
      dpll_pkg::ST_BP0: begin
        mul_a = 17'($signed(a1_q));    mul_b = 17'($signed(bpo1_q));
      end
      dpll_pkg::ST_BP1: begin
        mul_a = 17'($signed(bppole_q)); mul_b = 17'($signed(bpo2_q));
      end
      dpll_pkg::ST_BP2: begin
        mul_a = 17'($signed(bpgain_q)); mul_b = 17'($signed(x_q));
      end
      dpll_pkg::ST_BP3: begin
        mul_a = 17'($signed(b2));      mul_b = 17'($signed(bpi2_q));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= dpll_pkg::ST_IDLE;
      center_q <= dpll_pkg::RstCenterStep;
      gain_q   <= dpll_pkg::RstGain;
      alpha_q  <= dpll_pkg::RstAlpha;
      escale_q <= dpll_pkg::RstErrScale;
      decim_q  <= dpll_pkg::RstDecimation;
      bpgain_q <= dpll_pkg::RstBpGain;
      bppole_q <= dpll_pkg::RstBpPole;
      phase_q  <= '0;
      err_q    <= '0;
      integ_q  <= '0;
      dcnt_q   <= '0;
      held_q   <= '0;
      comb_q   <= '0;
      bpo1_q   <= '0;
      bpo2_q   <= '0;
      bpi1_q   <= '0;
      bpi2_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (dpll_pkg::cfg_reg_e'(cfg_index_i))
          dpll_pkg::REG_CENTER_STEP: center_q <= cfg_data_i;
          dpll_pkg::REG_GAIN:        gain_q   <= cfg_data_i;
          dpll_pkg::REG_ALPHA:       alpha_q  <= cfg_data_i[14:0];
          dpll_pkg::REG_ERR_SCALE:   escale_q <= cfg_data_i;
          dpll_pkg::REG_DECIMATION:  decim_q  <= cfg_data_i[7:0];
          dpll_pkg::REG_BP_GAIN:     bpgain_q <= cfg_data_i;
          dpll_pkg::REG_BP_POLE:     bppole_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == dpll_pkg::ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        dpll_pkg::ST_GAIN:
          phase_q <= phase_q + center_q + p32[30:15];
        dpll_pkg::ST_LB:
          err_q <= acc_sum[30:15];
        dpll_pkg::ST_ES: begin
          integ_q <= integ_new;
          if (dcnt_q > 8'd1) begin
            dcnt_q <= dcnt_q - 8'd1;
          end else begin
            dcnt_q <= decim_q;
            held_q <= 16'((integ_new - comb_q) >> 5);
            comb_q <= integ_new;
          end
        end
        dpll_pkg::ST_BP3: begin
          bpi2_q <= bpi1_q;
          bpi1_q <= x_q;
          bpo2_q <= bpo1_q;
          bpo1_q <= acc_sum[30:15];
        end
        default: ;
      endcase
    end
  end

  // datapath scratch registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      dpll_pkg::ST_IDLE:
        if (in_valid_i) x_q <= sample_in_i;
      dpll_pkg::ST_INTERP: begin
        // interpolate, then mirror for the negative half of the ramp
        if (phase_q[15])
          y_q <= 16'(-(dpll_pkg::half_sine({1'b0, ph_idx}) + p32[30:15]));
        else
          y_q <= dpll_pkg::half_sine({1'b0, ph_idx}) + p32[30:15];
      end
      dpll_pkg::ST_PD:  xd_q <= p32[30:15];
      dpll_pkg::ST_LA:  acc_q <= p32;
      dpll_pkg::ST_LB:  enew_q <= acc_sum[30:15];
      dpll_pkg::ST_KF: begin
        if (!held_q[15] && held_q != 16'd0)
          kf_q <= 17'(-(17'(dpll_pkg::half_sine({1'b0, cw_idx})) + p32[31:15]));
        else
          kf_q <= 17'(dpll_pkg::half_sine({1'b0, cw_idx})) + p32[31:15];
      end
      dpll_pkg::ST_A1:  a1_q <= p32[30:15];
      dpll_pkg::ST_BP0: acc_q <= {p32[30:0], 1'b0};
      dpll_pkg::ST_BP1: acc_q <= acc_sum;
      dpll_pkg::ST_BP2: acc_q <= acc_sum;
      dpll_pkg::ST_BP3: yn_q <= acc_sum[30:15];
      dpll_pkg::ST_OUT: begin
        if (out_free) begin
          out_err_q <= enew_q;
          out_cw_q  <= held_q;
          out_yn_q  <= yn_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o      = out_valid_q;
  assign loop_error_out_o = out_err_q;
  assign control_word_o   = out_cw_q;
  assign filtered_out_o   = out_yn_q;

endmodule
